[sv/rlerf_pkg.sv]
package rlerf_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned CNT_W          = 9;
  localparam int unsigned HEIGHT_W       = 9;
  localparam int unsigned COLOR_W        = 24;
  localparam int unsigned APB_DATA_W     = 32;
  localparam int unsigned ADDR_W         = 4;

  typedef enum logic [1:0] {
    REG_RECT_X       = 2'd0,
    REG_RECT_Y       = 2'd1,
    REG_RECT_WIDTH   = 2'd2,
    REG_FRAME_HEIGHT = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_DIV,
    ST_BODY,
    ST_TAIL
  } seq_state_e;

endpackage

[sv/rlerf_cfg.sv]
module rlerf_cfg #(
  parameter int unsigned COORD_BITS = rlerf_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rlerf_pkg::ADDR_W-1:0]        paddr,
  input  logic [rlerf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rlerf_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready,
  output logic [COORD_BITS-1:0]               rect_x_o,
  output logic [COORD_BITS-1:0]               rect_y_o,
  output logic [COORD_BITS-1:0]               rect_width_o,
  output logic [COORD_BITS-1:0]               frame_height_o
);
  import rlerf_pkg::*;

  localparam int unsigned PadW = APB_DATA_W - COORD_BITS;

  reg_idx_e              idx;
  logic                  wr_en;
  logic [COORD_BITS-1:0] rect_x_q, rect_y_q, rect_width_q, frame_height_q;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_x_q       <= '0;
      rect_y_q       <= '0;
      rect_width_q   <= COORD_BITS'(1);
      frame_height_q <= COORD_BITS'(1);
    end else if (wr_en) begin
      case (idx)
        REG_RECT_X:       rect_x_q       <= pwdata[COORD_BITS-1:0];
        REG_RECT_Y:       rect_y_q       <= pwdata[COORD_BITS-1:0];
        REG_RECT_WIDTH:   rect_width_q   <= pwdata[COORD_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RECT_X:       prdata = {{PadW{1'b0}}, rect_x_q};
      REG_RECT_Y:       prdata = {{PadW{1'b0}}, rect_y_q};
      REG_RECT_WIDTH:   prdata = {{PadW{1'b0}}, rect_width_q};
      REG_FRAME_HEIGHT: prdata = {{PadW{1'b0}}, frame_height_q};
      default:          prdata = '0;
    endcase
  end

  assign rect_x_o       = rect_x_q;
  assign rect_y_o       = rect_y_q;
  assign rect_width_o   = rect_width_q;
  assign frame_height_o = frame_height_q;

endmodule

[sv/rlerf_div.sv]
module rlerf_div #(
  parameter int unsigned COORD_BITS = rlerf_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rlerf_pkg::CNT_W-1:0]  dividend_i,
  input  logic [COORD_BITS-1:0]        divisor_i,
  output logic                         done_o,
  output logic [rlerf_pkg::CNT_W-1:0]  quot_o,
  output logic [rlerf_pkg::CNT_W-1:0]  rem_o
);
  import rlerf_pkg::*;

  localparam int unsigned AccW  = COORD_BITS + 1;
  localparam int unsigned PartW = COORD_BITS + 2;
  localparam int unsigned StepW = $clog2(CNT_W);

  logic                  busy_q, done_q;
  logic [StepW-1:0]      step_q;
  logic [CNT_W-1:0]      dq_q;
  logic [AccW-1:0]       acc_q, acc_d;
  logic [COORD_BITS-1:0] dvs_q;
  logic [PartW-1:0]      partial, dvs_ext, diff;
  logic                  ge;

  // one restoring compare-subtract step per cycle
  assign partial = {acc_q, dq_q[CNT_W-1]};
  assign dvs_ext = PartW'(dvs_q);
  assign ge      = partial >= dvs_ext;
  assign diff    = partial - dvs_ext;
  assign acc_d   = ge ? diff[AccW-1:0] : partial[AccW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= StepW'(CNT_W - 1);
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        step_q <= step_q - StepW'(1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      acc_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[CNT_W-2:0], ge};
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;
  assign rem_o  = acc_q[CNT_W-1:0];

endmodule

[sv/rlerf_seq.sv]
module rlerf_seq #(
  parameter int unsigned COORD_BITS = rlerf_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            new_rect_i,
  input  logic [rlerf_pkg::COLOR_W-1:0]   pixel_color_i,
  input  logic [7:0]                      run_count_i,
  input  logic [COORD_BITS-1:0]           rect_x_i,
  input  logic [COORD_BITS-1:0]           rect_y_i,
  input  logic [COORD_BITS-1:0]           rect_width_i,
  input  logic [COORD_BITS-1:0]           frame_height_i,
  output logic                            div_start_o,
  output logic [rlerf_pkg::CNT_W-1:0]     div_dividend_o,
  output logic [COORD_BITS-1:0]           div_divisor_o,
  input  logic                            div_done_i,
  input  logic [rlerf_pkg::CNT_W-1:0]     div_quot_i,
  input  logic [rlerf_pkg::CNT_W-1:0]     div_rem_i,
  output logic                            fill_valid_o,
  input  logic                            fill_ready_i,
  output logic [COORD_BITS:0]             fill_x_o,
  output logic [COORD_BITS-1:0]           fill_y_o,
  output logic [COORD_BITS-1:0]           fill_width_o,
  output logic [rlerf_pkg::HEIGHT_W-1:0]  fill_height_o,
  output logic [rlerf_pkg::COLOR_W-1:0]   fill_color_o,
  output logic                            last_of_run_o,
  output logic                            reached_bottom_o
);
  import rlerf_pkg::*;

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned WW = COORD_BITS + 1;

  seq_state_e state_q, state_d;

  logic [CW-1:0]       col_q, col_d, row_q, row_d;
  logic                stopped_q, stopped_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic [COLOR_W-1:0]  color_q;

  logic                out_valid_q;
  logic [WW-1:0]       fx_q, fx_d;
  logic [CW-1:0]       fy_q, fy_d, fw_q, fw_d;
  logic [HEIGHT_W-1:0] fh_q, fh_d;
  logic                flast_q, flast_d, fbot_q, fbot_d;
  logic                emit;

  logic [CW-1:0]       rw, space, take, free_rows;
  logic [WW-1:0]       n_w, n_after_w, row_plus, q_w, row_sum, row_free_sum, painted;
  logic [CNT_W-1:0]    n_after;
  logic                take_all, has_next, head_bot, head_last;
  logic                body_fit, body_any, slot_free, accept;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign slot_free = !out_valid_q || fill_ready_i;

  assign rw        = (rect_width_i == '0) ? CW'(1) : rect_width_i;
  assign n_w       = WW'(n_q);
  assign space     = (col_q < rw) ? (rw - col_q) : CW'(1);
  assign take_all  = n_w >= {1'b0, space};
  assign take      = take_all ? space : n_w[CW-1:0];
  assign n_after_w = n_w - {1'b0, take};
  assign n_after   = n_after_w[CNT_W-1:0];
  assign row_plus  = {1'b0, row_q} + WW'(1);
  assign has_next  = row_plus < {1'b0, frame_height_i};
  assign head_bot  = take_all && !has_next;
  assign head_last = !take_all || head_bot || (n_after == '0);

  assign free_rows    = has_next ? (frame_height_i - CW'(1) - row_q) : '0;
  assign q_w          = WW'(div_quot_i);
  assign body_any     = div_quot_i != '0;
  assign body_fit     = q_w <= {1'b0, free_rows};
  assign row_sum      = {1'b0, row_q} + q_w;
  assign row_free_sum = {1'b0, row_q} + {1'b0, free_rows};
  assign painted      = {1'b0, free_rows} + WW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_HEAD;
      end
      ST_HEAD: begin
        if (stopped_q) begin
          state_d = ST_IDLE;
        end else if (col_q == '0) begin
          state_d = ST_DIV;
        end else if (slot_free) begin
          state_d = head_last ? ST_IDLE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done_i) state_d = ST_BODY;
      end
      ST_BODY: begin
        if (!body_any) begin
          state_d = ST_TAIL;
        end else if (slot_free) begin
          state_d = (!body_fit || div_rem_i == '0) ? ST_IDLE : ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and fill word
  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    stopped_d   = stopped_q;
    n_d         = n_q;
    emit        = 1'b0;
    div_start_o = 1'b0;
    fx_d        = {1'b0, rect_x_i};
    fy_d        = row_q;
    fw_d        = rw;
    fh_d        = HEIGHT_W'(1);
    flast_d     = 1'b1;
    fbot_d      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          n_d = CNT_W'(run_count_i) + CNT_W'(1);
          if (new_rect_i) begin
            col_d     = '0;
            row_d     = rect_y_i;
            stopped_d = 1'b0;
          end
        end
      end
      ST_HEAD: begin
        if (!stopped_q) begin
          if (col_q == '0) begin
            div_start_o = 1'b1;
          end else if (slot_free) begin
            emit    = 1'b1;
            fx_d    = {1'b0, rect_x_i} + {1'b0, col_q};
            fw_d    = take;
            flast_d = head_last;
            fbot_d  = head_bot;
            n_d     = n_after;
            if (take_all) begin
              col_d = '0;
              if (has_next) row_d = row_plus[CW-1:0];
              else stopped_d = 1'b1;
            end else begin
              col_d = col_q + take;
            end
            if (!head_last) div_start_o = 1'b1;
          end
        end
      end
      ST_BODY: begin
        if (body_any && slot_free) begin
          emit = 1'b1;
          if (body_fit) begin
            fh_d    = div_quot_i;
            row_d   = row_sum[CW-1:0];
            n_d     = div_rem_i;
            flast_d = div_rem_i == '0;
          end else begin
            fh_d      = painted[HEIGHT_W-1:0];
            row_d     = row_free_sum[CW-1:0];
            col_d     = '0;
            stopped_d = 1'b1;
            fbot_d    = 1'b1;
          end
        end
      end
      ST_TAIL: begin
        if (slot_free) begin
          emit  = 1'b1;
          fw_d  = n_w[CW-1:0];
          col_d = n_w[CW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign div_dividend_o = (col_q == '0) ? n_q : n_after;
  assign div_divisor_o  = rw;
  assign in_ready_o     = state_q == ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      row_q     <= row_d;
      stopped_q <= stopped_d;
      if (emit) out_valid_q <= 1'b1;
      else if (fill_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    if (accept) color_q <= pixel_color_i;
    if (emit) begin
      fx_q    <= fx_d;
      fy_q    <= fy_d;
      fw_q    <= fw_d;
      fh_q    <= fh_d;
      flast_q <= flast_d;
      fbot_q  <= fbot_d;
    end
  end

  // color only changes on accept, which never happens while a fill is still being built
  logic [COLOR_W-1:0] fcolor_q;
  always_ff @(posedge clk_i) begin
    if (emit) fcolor_q <= color_q;
  end

  assign fill_valid_o     = out_valid_q;
  assign fill_x_o         = fx_q;
  assign fill_y_o         = fy_q;
  assign fill_width_o     = fw_q;
  assign fill_height_o    = fh_q;
  assign fill_color_o     = fcolor_q;
  assign last_of_run_o    = flast_q;
  assign reached_bottom_o = fbot_q;

endmodule

[sv/rle_rect_fill_writer.sv]
// channel   direction  handshake                  word
// in        input      in_valid_i / in_ready_o    new_rect, pixel_color, run_count
// fill      output     fill_valid_o / fill_ready_i fill_x/y/width/height/color, flags
// cfg       input      psel, penable, pwrite      rect_x, rect_y, rect_width, frame_height
//
// once painting has stopped a word goes from ST_HEAD straight back to idle; otherwise
// the 9-step restoring divider splits the run into whole rows, unless the head fill ends it
// the output register lets a new word in while the last fill waits to be taken
// a stall on the fill side holds the sequencer at its next fill
// reset clears position, stop flag, output valid, rect_x and rect_y; rect_width and frame_height reset to 1
module rle_rect_fill_writer #(
  parameter int unsigned COORD_BITS = rlerf_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              new_rect_i,
  input  logic [rlerf_pkg::COLOR_W-1:0]     pixel_color_i,
  input  logic [7:0]                        run_count_i,
  output logic                              fill_valid_o,
  input  logic                              fill_ready_i,
  output logic [COORD_BITS:0]               fill_x_o,
  output logic [COORD_BITS-1:0]             fill_y_o,
  output logic [COORD_BITS-1:0]             fill_width_o,
  output logic [rlerf_pkg::HEIGHT_W-1:0]    fill_height_o,
  output logic [rlerf_pkg::COLOR_W-1:0]     fill_color_o,
  output logic                              last_of_run_o,
  output logic                              reached_bottom_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rlerf_pkg::ADDR_W-1:0]      paddr,
  input  logic [rlerf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rlerf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                              pready
);
  import rlerf_pkg::*;

  logic [COORD_BITS-1:0] rect_x, rect_y, rect_width, frame_height;
  logic                  div_start, div_done;
  logic [CNT_W-1:0]      div_dividend, div_quot, div_rem;
  logic [COORD_BITS-1:0] div_divisor;

  rlerf_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .rect_x_o       (rect_x),
    .rect_y_o       (rect_y),
    .rect_width_o   (rect_width),
    .frame_height_o (frame_height)
  );

  rlerf_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  rlerf_seq #(.COORD_BITS(COORD_BITS)) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .new_rect_i       (new_rect_i),
    .pixel_color_i    (pixel_color_i),
    .run_count_i      (run_count_i),
    .rect_x_i         (rect_x),
    .rect_y_i         (rect_y),
    .rect_width_i     (rect_width),
    .frame_height_i   (frame_height),
    .div_start_o      (div_start),
    .div_dividend_o   (div_dividend),
    .div_divisor_o    (div_divisor),
    .div_done_i       (div_done),
    .div_quot_i       (div_quot),
    .div_rem_i        (div_rem),
    .fill_valid_o     (fill_valid_o),
    .fill_ready_i     (fill_ready_i),
    .fill_x_o         (fill_x_o),
    .fill_y_o         (fill_y_o),
    .fill_width_o     (fill_width_o),
    .fill_height_o    (fill_height_o),
    .fill_color_o     (fill_color_o),
    .last_of_run_o    (last_of_run_o),
    .reached_bottom_o (reached_bottom_o)
  );

endmodule

[sv/rlerf_checker.sv]
module rlerf_checker #(
  parameter int unsigned COORD_BITS = rlerf_pkg::COORD_BITS_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            fill_valid_o,
  input logic                            fill_ready_i,
  input logic [COORD_BITS:0]             fill_x_o,
  input logic [COORD_BITS-1:0]           fill_y_o,
  input logic [COORD_BITS-1:0]           fill_width_o,
  input logic [rlerf_pkg::HEIGHT_W-1:0]  fill_height_o,
  input logic                            last_of_run_o,
  input logic                            reached_bottom_o
);
  import rlerf_pkg::*;

  // a fill word waiting on the sink holds still
  a_fill_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_valid_o && !fill_ready_i |=> fill_valid_o && $stable(fill_x_o)
      && $stable(fill_y_o) && $stable(fill_width_o) && $stable(fill_height_o))
    else $error("fill word changed while stalled");

  a_fill_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_valid_o |-> fill_width_o != '0 && fill_height_o != '0
      && fill_height_o <= HEIGHT_W'(256))
    else $error("fill size out of range");

  a_bottom_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_valid_o && reached_bottom_o |-> last_of_run_o)
    else $error("bottom reached on a fill that is not the last");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accepting a word");

endmodule

bind rle_rect_fill_writer rlerf_checker #(.COORD_BITS(COORD_BITS)) u_rlerf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .fill_valid_o     (fill_valid_o),
  .fill_ready_i     (fill_ready_i),
  .fill_x_o         (fill_x_o),
  .fill_y_o         (fill_y_o),
  .fill_width_o     (fill_width_o),
  .fill_height_o    (fill_height_o),
  .last_of_run_o    (last_of_run_o),
  .reached_bottom_o (reached_bottom_o)
);
